// ===== rtl/midi_track_event_parser_defines.svh =====
// Assertion macros used by the checker file.
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH

// Checked only outside reset.
`define MTEP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MTEP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mtep_pkg.sv =====
package mtep_pkg;

  localparam int DELTA_W = 28;
  localparam int TEMPO_W = 24;
  localparam int DIV_W   = 15;
  localparam int DIV_CW  = $clog2(TEMPO_W);
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [7:0]         STATUS_META   = 8'hFF;
  localparam logic [7:0]         META_TEMPO    = 8'h51;
  localparam logic [7:0]         META_EOT      = 8'h2F;
  localparam logic [3:0]         HI_SYSTEM     = 4'hF;
  localparam logic [3:0]         HI_PROGRAM    = 4'hC;
  localparam logic [3:0]         HI_PRESSURE   = 4'hD;
  localparam logic [7:0]         TEMPO_NBYTES  = 8'd3;
  localparam logic [TEMPO_W-1:0] TEMPO_DEFAULT = 24'd500000;
  localparam logic [DIV_W-1:0]   DIVISION_RST  = 15'd480;
  localparam logic [TEMPO_W-1:0] TICK_RST      = TEMPO_W'(500000 / 480);

  // register index, taken from paddr[2]
  localparam logic REG_DIVISION    = 1'b0;
  localparam logic REG_TICK_PERIOD = 1'b1;

  typedef enum logic [1:0] {
    KIND_CHAN  = 2'd0,
    KIND_TEMPO = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERR   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [TEMPO_W-1:0] tempo;
  } q_entry_t;

  typedef struct packed {
    logic               start;
    logic [TEMPO_W-1:0] dividend;
    logic [DIV_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [TEMPO_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic one_data_byte(input logic [7:0] status);
    return (status[7:4] == HI_PROGRAM) || (status[7:4] == HI_PRESSURE);
  endfunction

endpackage

// ===== rtl/mtep_byte_if.sv =====
interface mtep_byte_if import mtep_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;

  modport source(output valid, output track_byte, input ready);
  modport sink(input valid, input track_byte, output ready);
endinterface

// ===== rtl/mtep_kind_if.sv =====
interface mtep_kind_if import mtep_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;

  modport source(output valid, output kind, input ready);
  modport sink(input valid, input kind, output ready);
endinterface

// ===== rtl/mtep_queue.sv =====
module mtep_queue import mtep_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t head,
  output logic     empty,
  output logic     full
);

  q_entry_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign head  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == (Q_AW+1)'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (!push && pop) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

// ===== rtl/mtep_front.sv =====
module mtep_front import mtep_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  mtep_byte_if.sink in_ch,
  input  logic     q_full,
  output logic     push,
  output q_entry_t push_entry
);

  typedef enum logic [9:0] {
    PH_DELTA  = 10'b00_0000_0001,
    PH_STATUS = 10'b00_0000_0010,
    PH_DATA1  = 10'b00_0000_0100,
    PH_DATA2  = 10'b00_0000_1000,
    PH_MTYPE  = 10'b00_0001_0000,
    PH_MLEN   = 10'b00_0010_0000,
    PH_TEMPO  = 10'b00_0100_0000,
    PH_SKIP   = 10'b00_1000_0000,
    PH_DONE   = 10'b01_0000_0000,
    PH_ERROR  = 10'b10_0000_0000
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [DELTA_W-1:0] delta_r, delta_nxt;
  logic [7:0]         rs_r, rs_nxt;
  logic [7:0]         meta_r, meta_nxt;
  logic [7:0]         skip_r, skip_nxt;
  logic [TEMPO_W-1:0] tempo_r, tempo_nxt;
  logic [7:0]         b;
  logic [7:0]         skip_dec;
  logic               accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.track_byte;
  assign skip_dec    = skip_r - 8'd1;

  always_comb begin
    phase_nxt        = phase_r;
    delta_nxt        = delta_r;
    rs_nxt           = rs_r;
    meta_nxt         = meta_r;
    skip_nxt         = skip_r;
    tempo_nxt        = tempo_r;
    push             = 1'b0;
    push_entry.kind  = KIND_CHAN;
    push_entry.tempo = tempo_r;
    if (accept) begin
      unique case (phase_r)
        PH_DELTA: begin
          delta_nxt = {delta_r[DELTA_W-8:0], b[6:0]};
          if (!b[7]) phase_nxt = PH_STATUS;
        end
        PH_STATUS: begin
          if (!b[7]) begin
            if (rs_r == '0) begin
              phase_nxt       = PH_ERROR;
              push            = 1'b1;
              push_entry.kind = KIND_ERR;
            end else if (one_data_byte(rs_r)) begin
              phase_nxt = PH_DELTA;
              delta_nxt = '0;
              push      = 1'b1;
            end else begin
              phase_nxt = PH_DATA2;
            end
          end else if (b == STATUS_META) begin
            phase_nxt = PH_MTYPE;
          end else if (b[7:4] == HI_SYSTEM) begin
            phase_nxt       = PH_ERROR;
            push            = 1'b1;
            push_entry.kind = KIND_ERR;
          end else begin
            rs_nxt    = b;
            phase_nxt = PH_DATA1;
          end
        end
        PH_DATA1: begin
          if (one_data_byte(rs_r)) begin
            phase_nxt = PH_DELTA;
            delta_nxt = '0;
            push      = 1'b1;
          end else begin
            phase_nxt = PH_DATA2;
          end
        end
        PH_DATA2: begin
          phase_nxt = PH_DELTA;
          delta_nxt = '0;
          push      = 1'b1;
        end
        PH_MTYPE: begin
          meta_nxt = b;
          if (b == META_EOT) begin
            phase_nxt       = PH_DONE;
            push            = 1'b1;
            push_entry.kind = KIND_END;
          end else begin
            phase_nxt = PH_MLEN;
          end
        end
        PH_MLEN: begin
          if (meta_r == META_TEMPO) begin
            tempo_nxt = '0;
            skip_nxt  = TEMPO_NBYTES;
            phase_nxt = PH_TEMPO;
          end else if (b == '0) begin
            skip_nxt  = '0;
            phase_nxt = PH_DELTA;
            delta_nxt = '0;
          end else begin
            skip_nxt  = b;
            phase_nxt = PH_SKIP;
          end
        end
        PH_TEMPO: begin
          tempo_nxt = {tempo_r[TEMPO_W-9:0], b};
          skip_nxt  = skip_dec;
          if (skip_dec == '0) begin
            phase_nxt        = PH_DELTA;
            delta_nxt        = '0;
            push             = 1'b1;
            push_entry.kind  = KIND_TEMPO;
            push_entry.tempo = {tempo_r[TEMPO_W-9:0], b};
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            phase_nxt = PH_DELTA;
            delta_nxt = '0;
          end
        end
        PH_DONE: begin
        end
        default: begin
          phase_nxt       = PH_ERROR;
          push            = 1'b1;
          push_entry.kind = KIND_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      delta_r <= '0;
      rs_r    <= '0;
      meta_r  <= '0;
      skip_r  <= '0;
      tempo_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      delta_r <= delta_nxt;
      rs_r    <= rs_nxt;
      meta_r  <= meta_nxt;
      skip_r  <= skip_nxt;
      tempo_r <= tempo_nxt;
    end
  end

endmodule

// ===== rtl/mtep_div.sv =====
module mtep_div import mtep_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy_r, done_r;
  logic [DIV_CW-1:0]  cnt_r;
  logic [TEMPO_W-1:0] quo_r;
  logic [DIV_W:0]     rem_r;
  logic [DIV_W-1:0]   dsr_r;
  logic [DIV_W:0]     rem_sh;
  logic [DIV_W+1:0]   diff;
  logic               q_bit;

  assign rem_sh = {rem_r[DIV_W-1:0], quo_r[TEMPO_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_r};
  assign q_bit  = !diff[DIV_W+1];

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(TEMPO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[TEMPO_W-2:0], q_bit};
      rem_r <= q_bit ? diff[DIV_W:0] : rem_sh;
    end
  end

endmodule

// ===== rtl/mtep_back.sv =====
module mtep_back import mtep_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  q_entry_t           q_head,
  input  logic               q_empty,
  output logic               pop,
  input  logic               cfg_div,
  input  logic [DIV_W-1:0]   divisor,
  output logic [TEMPO_W-1:0] tick_period,
  mtep_kind_if.source        out_ch
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_WAIT = 3'b100
  } bstate_t;

  bstate_t            state_r, state_nxt;
  logic               job_cfg_r, job_cfg_nxt;
  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r, out_kind_nxt;
  logic [TEMPO_W-1:0] tick_r, tick_nxt;
  logic               slot_free, load;
  kind_t              load_kind;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  mtep_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign slot_free    = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_kind_r;
  assign tick_period  = tick_r;

  always_comb begin
    state_nxt        = state_r;
    job_cfg_nxt      = job_cfg_r;
    tick_nxt         = tick_r;
    pop              = 1'b0;
    load             = 1'b0;
    load_kind        = q_head.kind;
    div_req.start    = 1'b0;
    div_req.dividend = q_head.tempo;
    div_req.divisor  = divisor;
    if (cfg_div) begin
      div_req.start    = 1'b1;
      div_req.dividend = TEMPO_DEFAULT;
      job_cfg_nxt      = 1'b1;
      state_nxt        = B_DIV;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty && slot_free) begin
            pop = 1'b1;
            if (q_head.kind == KIND_TEMPO) begin
              div_req.start = 1'b1;
              job_cfg_nxt   = 1'b0;
              state_nxt     = B_DIV;
            end else begin
              load = 1'b1;
            end
          end
        end
        B_DIV: begin
          if (div_rsp.done) begin
            tick_nxt  = div_rsp.quotient;
            state_nxt = job_cfg_r ? B_IDLE : B_WAIT;
          end
        end
        B_WAIT: begin
          if (slot_free) begin
            load      = 1'b1;
            load_kind = KIND_TEMPO;
            state_nxt = B_IDLE;
          end
        end
        default: state_nxt = B_IDLE;
      endcase
    end
    out_valid_nxt = load ? 1'b1 : (out_valid_r && !out_ch.ready);
    out_kind_nxt  = load ? load_kind : out_kind_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      job_cfg_r   <= 1'b0;
      out_valid_r <= 1'b0;
      tick_r      <= TICK_RST;
    end else begin
      state_r     <= state_nxt;
      job_cfg_r   <= job_cfg_nxt;
      out_valid_r <= out_valid_nxt;
      tick_r      <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
  end

endmodule

// ===== rtl/midi_track_event_parser.sv =====
// MIDI track body parser. One track byte is taken per transfer on in_ch; a
// byte that completes a channel message, a tempo meta event, end of track or
// an unsupported status yields one kind code on out_ch, in byte order. The
// byte parser takes one byte per cycle while its 4-entry result queue has
// room. Each tempo event goes through a bit-serial divider
// (tempo / division), so its result reaches out_ch only once the divider
// is done, and results queued behind it wait; sustained rate is therefore
// one byte per cycle while out_ch is ready, except around tempo events.
// Register map: byte address 0 is division (15 bits, reset 480, zero acts
// as one); a write to it also recomputes the tick period (500000 / division)
// in the divider, and the new tick period reads back once it is done.
// Byte address 4 reads the current tick period in microseconds (read only).
// After end of track all bytes are dropped; after an error every byte is
// answered with the error code until reset.
module midi_track_event_parser import mtep_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  mtep_byte_if.sink         in_ch,
  mtep_kind_if.source       out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [DIV_W-1:0]   division_r;
  logic               cfg_div_r;
  logic               wr_en;
  logic [DIV_W-1:0]   divisor;
  logic [TEMPO_W-1:0] tick_period;
  logic               push, pop, q_empty, q_full;
  q_entry_t           push_entry, q_head;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && (paddr[2] == REG_DIVISION);
  assign divisor = (division_r == '0) ? DIV_W'(1) : division_r;

  always_comb begin
    unique case (paddr[2])
      REG_DIVISION:    prdata = CFG_DW'(division_r);
      REG_TICK_PERIOD: prdata = CFG_DW'(tick_period);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      division_r <= DIVISION_RST;
      cfg_div_r  <= 1'b0;
    end else begin
      cfg_div_r <= wr_en;
      if (wr_en) division_r <= pwdata[DIV_W-1:0];
    end
  end

  mtep_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_entry(push_entry)
  );

  mtep_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  mtep_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .pop        (pop),
    .cfg_div    (cfg_div_r),
    .divisor    (divisor),
    .tick_period(tick_period),
    .out_ch     (out_ch)
  );

endmodule

// ===== rtl/mtep_checker.sv =====
`include "midi_track_event_parser_defines.svh"

module mtep_checker import mtep_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind
);

  `MTEP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `MTEP_ASSERT(a_kind_hold, out_valid && !out_ready |=> $stable(out_kind), "result changed while stalled")
  `MTEP_ASSERT(a_end_last, out_valid && out_ready && (out_kind == KIND_END) |=> !out_valid, "result after end of track")
  `MTEP_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid, "result valid after reset")
  `MTEP_ASSERT_RST(a_rst_in, !rst_n |=> in_ready, "input not ready after reset")

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_kind (out_ch.kind)
);

// ===== dv/midi_track_event_parser_tb.sv =====
module midi_track_event_parser_tb;
  import mtep_pkg::*;

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_MTYPE,
    PH_MLEN, PH_TEMPO, PH_SKIP, PH_DONE, PH_ERROR
  } parse_phase_t;

  typedef enum logic [1:0] {EXP_PARSED, EXP_NONE, EXP_KIND} row_check_t;

  typedef struct packed {
    logic [7:0] track_byte;
    row_check_t chk;
    kind_t      kind;
  } track_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata, prdata;

  mtep_byte_if in_ch();
  mtep_kind_if out_ch();

  midi_track_event_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  localparam logic [CFG_AW-1:0] DIVISION_ADDR = {REG_DIVISION, 2'b00};

  // parser image
  parse_phase_t    phase;
  logic [27:0]     delta_ticks;
  logic [7:0]      run_status;
  logic [6:0]      data_lo;
  logic [7:0]      meta_type;
  logic [7:0]      bytes_left;
  logic [23:0]     tempo_acc;
  logic [23:0]     tick_us;
  logic [DIV_W-1:0] division_r;

  kind_t kind_q[$];
  kind_t exp_kind;
  int    errors = 0;
  int    results_seen = 0;
  int    bytes_sent = 0;
  bit    send_burst = 0;
  bit    recv_burst = 0;
  bit    held = 0;

  track_row_t directed_rows [25] = '{
    '{8'h00, EXP_NONE,   KIND_CHAN},
    '{8'h90, EXP_PARSED, KIND_CHAN},
    '{8'h3C, EXP_NONE,   KIND_CHAN},
    '{8'h7F, EXP_KIND,   KIND_CHAN},
    '{8'h81, EXP_NONE,   KIND_CHAN},
    '{8'h00, EXP_NONE,   KIND_CHAN},
    '{8'hC5, EXP_PARSED, KIND_CHAN},
    '{8'hFF, EXP_KIND,   KIND_CHAN},
    '{8'hFF, EXP_NONE,   KIND_CHAN},
    '{8'h7F, EXP_NONE,   KIND_CHAN},
    '{8'h40, EXP_KIND,   KIND_CHAN},
    '{8'h00, EXP_NONE,   KIND_CHAN},
    '{8'hFF, EXP_NONE,   KIND_CHAN},
    '{8'h51, EXP_NONE,   KIND_CHAN},
    '{8'h00, EXP_NONE,   KIND_CHAN},
    '{8'hFF, EXP_PARSED, KIND_CHAN},
    '{8'hFF, EXP_PARSED, KIND_CHAN},
    '{8'hFF, EXP_KIND,   KIND_TEMPO},
    '{8'h00, EXP_NONE,   KIND_CHAN},
    '{8'hFF, EXP_NONE,   KIND_CHAN},
    '{8'h01, EXP_NONE,   KIND_CHAN},
    '{8'h00, EXP_NONE,   KIND_CHAN},
    '{8'h00, EXP_PARSED, KIND_CHAN},
    '{8'hD0, EXP_PARSED, KIND_CHAN},
    '{8'h00, EXP_KIND,   KIND_CHAN}
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit single_data(input logic [7:0] status);
    return status[7:4] == HI_PROGRAM || status[7:4] == HI_PRESSURE;
  endfunction

  function automatic void set_division(input logic [DIV_W-1:0] v);
    division_r = v;
    tick_us = TEMPO_DEFAULT / ((v == '0) ? 24'd1 : 24'(v));
  endfunction

  // advance the parser image by one byte; returns 1 when a result is due
  function automatic bit parse_track_byte(input logic [7:0] b, output kind_t k);
    k = KIND_CHAN;
    case (phase)
      PH_DELTA: begin
        delta_ticks = {delta_ticks[20:0], b[6:0]};
        if (!b[7]) phase = PH_STATUS;
        return 0;
      end
      PH_STATUS: begin
        if (!b[7]) begin
          if (run_status == 8'h00) begin
            phase = PH_ERROR;
            k = KIND_ERR;
            return 1;
          end
          data_lo = b[6:0];
          if (single_data(run_status)) begin
            phase = PH_DELTA;
            delta_ticks = '0;
            return 1;
          end
          phase = PH_DATA2;
          return 0;
        end
        if (b == STATUS_META) begin
          phase = PH_MTYPE;
          return 0;
        end
        if (b[7:4] == HI_SYSTEM) begin
          phase = PH_ERROR;
          k = KIND_ERR;
          return 1;
        end
        run_status = b;
        phase = PH_DATA1;
        return 0;
      end
      PH_DATA1: begin
        data_lo = b[6:0];
        if (single_data(run_status)) begin
          phase = PH_DELTA;
          delta_ticks = '0;
          return 1;
        end
        phase = PH_DATA2;
        return 0;
      end
      PH_DATA2: begin
        phase = PH_DELTA;
        delta_ticks = '0;
        return 1;
      end
      PH_MTYPE: begin
        meta_type = b;
        if (b == META_EOT) begin
          phase = PH_DONE;
          k = KIND_END;
          return 1;
        end
        phase = PH_MLEN;
        return 0;
      end
      PH_MLEN: begin
        if (meta_type == META_TEMPO) begin
          tempo_acc = '0;
          bytes_left = TEMPO_NBYTES;
          phase = PH_TEMPO;
        end else if (b == 8'h00) begin
          bytes_left = '0;
          phase = PH_DELTA;
          delta_ticks = '0;
        end else begin
          bytes_left = b;
          phase = PH_SKIP;
        end
        return 0;
      end
      PH_TEMPO: begin
        tempo_acc = {tempo_acc[15:0], b};
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'h00) begin
          tick_us = tempo_acc / ((division_r == '0) ? 24'd1 : 24'(division_r));
          phase = PH_DELTA;
          delta_ticks = '0;
          k = KIND_TEMPO;
          return 1;
        end
        return 0;
      end
      PH_SKIP: begin
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'h00) begin
          phase = PH_DELTA;
          delta_ticks = '0;
        end
        return 0;
      end
      PH_DONE: return 0;
      default: begin
        phase = PH_ERROR;
        k = KIND_ERR;
        return 1;
      end
    endcase
  endfunction

  task automatic send_row(input track_row_t row);
    int gap;
    kind_t k;
    bit got;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.track_byte <= row.track_byte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = parse_track_byte(row.track_byte, k);
    case (row.chk)
      EXP_PARSED: if (got) kind_q.push_back(k);
      EXP_KIND: kind_q.push_back(row.kind);
      default: ;
    endcase
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_row('{b, EXP_PARSED, KIND_CHAN});
  endtask

  function automatic logic [7:0] data_byte();
    return ($urandom_range(0, 15) == 0) ? 8'($urandom) : {1'b0, 7'($urandom)};
  endfunction

  task automatic send_random_event();
    int n_delta;
    int pick;
    int len;
    logic [7:0] b;
    n_delta = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 4) : 1;
    repeat (n_delta - 1) send_byte({1'b1, 7'($urandom)});
    send_byte({1'b0, 7'($urandom)});
    pick = $urandom_range(0, 99);
    if (pick < 30 && run_status != 8'h00) begin
      send_byte({1'b0, 7'($urandom)});
      if (!single_data(run_status)) send_byte(data_byte());
    end else if (pick < 75) begin
      b = {4'($urandom_range(8, 14)), 4'($urandom)};
      send_byte(b);
      send_byte(data_byte());
      if (!single_data(b)) send_byte(data_byte());
    end else if (pick < 87) begin
      send_byte(STATUS_META);
      send_byte(META_TEMPO);
      send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : TEMPO_NBYTES);
      repeat (3) send_byte(8'($urandom));
    end else begin
      send_byte(STATUS_META);
      do b = 8'($urandom); while (b == META_EOT || b == META_TEMPO);
      send_byte(b);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 255) : $urandom_range(0, 6);
      send_byte(8'(len));
      repeat (len) send_byte(8'($urandom));
    end
  endtask

  task automatic write_division(input logic [DIV_W-1:0] v);
    logic [CFG_DW-1:0] w;
    w = $urandom;
    w[DIV_W-1:0] = v;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DIVISION_ADDR;
    pwdata <= w;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    set_division(v);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== CFG_DW'(division_r)) begin
      $display("%0t: division readback, expected %0d got %0d", $time, division_r, prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    while (kind_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (kind_q.size() == 0) begin
        $display("%0t: kind, expected none got %0d", $time, out_ch.kind);
        errors++;
      end else begin
        exp_kind = kind_q.pop_front();
        if (out_ch.kind !== exp_kind) begin
          $display("%0t: kind, expected %0d got %0d", $time, exp_kind, out_ch.kind);
          errors++;
        end
      end
    end
  end

  // result side: random stalls, one long hold-off to back up the queue
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = recv_burst ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      if (!held && results_seen >= 40) begin
        held = 1;
        gap = gap + 250;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [DIV_W-1:0] div_plan [5];
    int start;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.track_byte <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    phase = PH_DELTA;
    delta_ticks = '0;
    run_status = '0;
    data_lo = '0;
    meta_type = '0;
    bytes_left = '0;
    tempo_acc = '0;
    set_division(DIVISION_RST);
    div_plan = '{15'd1, 15'd0, 15'h7FFF, DIV_W'($urandom_range(1, 32767)), DIVISION_RST};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_row(directed_rows[i]);

    for (int p = 0; p < 5; p++) begin
      in_ch.valid <= 1'b0;
      drain();
      write_division(div_plan[p]);
      start = bytes_sent;
      while (bytes_sent - start < 240) send_random_event();
    end

    // close the track: either end of track or a system status, then trailing bytes
    send_byte(8'h00);
    if ($urandom_range(0, 1) == 0) begin
      send_byte(STATUS_META);
      send_byte(META_EOT);
    end else begin
      send_byte(8'($urandom_range(8'hF0, 8'hFE)));
    end
    repeat (20) send_byte(8'($urandom));
    in_ch.valid <= 1'b0;

    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
